// File: sv/urm_pkg.sv
// Shared constants and types for the ultrasonic range meter.
// Holds the counter width, register map and phase codes used by the top level.
// No dependencies.
package urm_pkg;

    // Tick counter width; counters saturate at all ones
    localparam int COUNT_BITS = 20;

    // Configuration field widths
    localparam int TICK_W  = 20;
    localparam int TRIG_W  = 8;
    localparam int SCALE_W = 16;
    localparam int MAXD_W  = 9;
    localparam int DIST_W  = 17;

    // APB geometry: six 32-bit registers at byte address 4*i
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ENABLE  = 3'd0;
    localparam t_reg_idx REG_IDLE    = 3'd1;
    localparam t_reg_idx REG_TRIGGER = 3'd2;
    localparam t_reg_idx REG_TIMEOUT = 3'd3;
    localparam t_reg_idx REG_SCALE   = 3'd4;
    localparam t_reg_idx REG_MAXDIST = 3'd5;

    // Measurement phases
    typedef logic [1:0] t_phase;
    localparam t_phase PH_IDLE = 2'd0;
    localparam t_phase PH_TRIG = 2'd1;
    localparam t_phase PH_RISE = 2'd2;
    localparam t_phase PH_HIGH = 2'd3;

endpackage

// File: sv/ultrasonic_range_meter_unit.sv
// Ultrasonic range meter top level: tick sequencer, width-to-distance conversion,
// APB register file and valid/stall pipeline. Depends on urm_pkg.
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------
// tick in   | input     | i_in_valid / o_in_stall   | i_echo_level
// reading   | output    | o_out_valid / i_out_stall | o_trigger_level, o_distance_q8,
//           |           |                           | o_in_range, o_reading_done
// config    | input     | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One request per cycle sustained while the output is not stalled; each request taken passes
// the input register, then the sequencer step and the 20x16 width multiply into the result
// register. The multiply-compare path sets the cycle time.
// Reset is synchronous and active low; the config registers take their defaults and
// no clearing pass is needed. A stalled result holds and the input register still
// takes one more request; the input stalls only when both stages are full.
module ultrasonic_range_meter_unit
    import urm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // tick requests
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_echo_level,
    // readings
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_trigger_level,
    output logic [DIST_W-1:0]  o_distance_q8,
    output logic               o_in_range,
    output logic               o_reading_done,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CMP_W  = 33;
    localparam int PROD_W = COUNT_BITS + SCALE_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Saturating increment
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + COUNT_BITS'(1);
    endfunction

    // Wait is over at the target (zero counts as one) or at saturation
    function automatic logic reached(input logic [COUNT_BITS-1:0] c,
                                     input logic [TICK_W-1:0] target);
        logic [CMP_W-1:0] ce;
        logic [CMP_W-1:0] te;
        ce = CMP_W'(c);
        te = (target == '0) ? CMP_W'(1) : CMP_W'(target);
        return (ce >= te) || (c == CNT_MAX);
    endfunction

    // Configuration registers
    logic              r_enable;
    logic [TICK_W-1:0] r_idle_ticks;
    logic [TRIG_W-1:0] r_trigger_ticks;
    logic [TICK_W-1:0] r_timeout_ticks;
    logic [SCALE_W-1:0] r_scale_q16;
    logic [MAXD_W-1:0] r_max_distance_cm;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // Register writes; indexes past the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable          <= 1'b0;
            r_idle_ticks      <= TICK_W'(500000);
            r_trigger_ticks   <= TRIG_W'(10);
            r_timeout_ticks   <= TICK_W'(200000);
            r_scale_q16       <= SCALE_W'(1124);
            r_max_distance_cm <= MAXD_W'(100);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLE:  r_enable          <= pwdata[0];
                REG_IDLE:    r_idle_ticks      <= pwdata[TICK_W-1:0];
                REG_TRIGGER: r_trigger_ticks   <= pwdata[TRIG_W-1:0];
                REG_TIMEOUT: r_timeout_ticks   <= pwdata[TICK_W-1:0];
                REG_SCALE:   r_scale_q16       <= pwdata[SCALE_W-1:0];
                REG_MAXDIST: r_max_distance_cm <= pwdata[MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE:  prdata = PDATA_W'(r_enable);
            REG_IDLE:    prdata = PDATA_W'(r_idle_ticks);
            REG_TRIGGER: prdata = PDATA_W'(r_trigger_ticks);
            REG_TIMEOUT: prdata = PDATA_W'(r_timeout_ticks);
            REG_SCALE:   prdata = PDATA_W'(r_scale_q16);
            REG_MAXDIST: prdata = PDATA_W'(r_max_distance_cm);
            default:     prdata = '0;
        endcase
    end

    // Pipeline control
    logic r_in_vld;
    logic r_echo;
    logic r_out_vld;
    logic advance;
    logic step;

    assign advance    = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_echo <= i_echo_level;
        end
    end

    // Sequencer state
    t_phase                r_phase;
    logic [COUNT_BITS-1:0] r_tick_count;
    logic [COUNT_BITS-1:0] r_pulse_width;
    logic                  r_prev_echo;
    logic [DIST_W-1:0]     r_last_distance;
    logic                  r_last_in_range;

    t_phase                n_phase;
    logic [COUNT_BITS-1:0] n_tick_count;
    logic [COUNT_BITS-1:0] n_pulse_width;
    logic [DIST_W-1:0]     n_last_distance;
    logic                  n_last_in_range;
    logic                  n_trigger;
    logic                  n_done;

    // Width to distance: cm in Q16, limit check, Q8 result
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] limit;
    logic              too_far;

    assign prod    = PROD_W'(r_pulse_width) * PROD_W'(r_scale_q16);
    assign limit   = PROD_W'({r_max_distance_cm, 16'h0000});
    assign too_far = prod > limit;

    // Next state for one tick
    always_comb begin
        n_phase         = r_phase;
        n_tick_count    = r_tick_count;
        n_pulse_width   = r_pulse_width;
        n_last_distance = r_last_distance;
        n_last_in_range = r_last_in_range;
        n_trigger       = 1'b0;
        n_done          = 1'b0;
        if (!r_enable) begin
            n_phase       = PH_IDLE;
            n_tick_count  = '0;
            n_pulse_width = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_tick_count = bump(r_tick_count);
                    if (reached(n_tick_count, r_idle_ticks)) begin
                        n_phase      = PH_TRIG;
                        n_tick_count = '0;
                    end
                end
                PH_TRIG: begin
                    n_trigger    = 1'b1;
                    n_tick_count = bump(r_tick_count);
                    if (reached(n_tick_count, TICK_W'(r_trigger_ticks))) begin
                        n_phase      = PH_RISE;
                        n_tick_count = '0;
                    end
                end
                PH_RISE: begin
                    if (r_echo && !r_prev_echo) begin
                        n_phase       = PH_HIGH;
                        n_pulse_width = COUNT_BITS'(1);
                        n_tick_count  = '0;
                    end else begin
                        n_tick_count = bump(r_tick_count);
                        if (reached(n_tick_count, r_timeout_ticks)) begin
                            n_last_distance = '0;
                            n_last_in_range = 1'b0;
                            n_done          = 1'b1;
                            n_phase         = PH_IDLE;
                            n_tick_count    = '0;
                        end
                    end
                end
                PH_HIGH: begin
                    if (!r_echo) begin
                        // falling edge closes the pulse
                        if (too_far) begin
                            n_last_distance = '0;
                            n_last_in_range = 1'b0;
                        end else begin
                            n_last_distance = prod[8 +: DIST_W];
                            n_last_in_range = 1'b1;
                        end
                        n_done       = 1'b1;
                        n_phase      = PH_IDLE;
                        n_tick_count = '0;
                    end else begin
                        n_pulse_width = bump(r_pulse_width);
                        if (reached(n_pulse_width, r_timeout_ticks)) begin
                            n_last_distance = '0;
                            n_last_in_range = 1'b0;
                            n_done          = 1'b1;
                            n_phase         = PH_IDLE;
                            n_tick_count    = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State commit on each processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_tick_count    <= '0;
            r_pulse_width   <= '0;
            r_prev_echo     <= 1'b0;
            r_last_distance <= '0;
            r_last_in_range <= 1'b0;
        end else if (step) begin
            r_phase         <= n_phase;
            r_tick_count    <= n_tick_count;
            r_pulse_width   <= n_pulse_width;
            r_prev_echo     <= r_echo;
            r_last_distance <= n_last_distance;
            r_last_in_range <= n_last_in_range;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_trigger_level <= n_trigger;
            o_distance_q8   <= n_last_distance;
            o_in_range      <= n_last_in_range;
            o_reading_done  <= n_done;
        end
    end

    assign o_out_valid = r_out_vld;

    // Trigger and reading completion come from different phases
    a_trig_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_trigger_level) |-> !o_reading_done)
        else $error("trigger high on a completed reading");

    // Out-of-range readings carry zero distance
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |-> (o_distance_q8 == '0))
        else $error("out-of-range reading with nonzero distance");

    // A freshly stored in-range reading never exceeds the configured maximum
    a_in_range_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_range && o_reading_done) |->
            (o_distance_q8 <= DIST_W'({r_max_distance_cm, 8'h00})))
        else $error("in-range distance above maximum");

    // A completed reading always leaves the sequencer back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && n_done) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after a reading");

endmodule

// File: tb/sv/ultrasonic_range_meter_unit_test.sv
// Self-checking testbench for ultrasonic_range_meter_unit: tick requests in, readings out.
// A mirror class predicts every reading; plain tasks drive ticks and APB register writes.
// Depends on urm_pkg and the ultrasonic_range_meter_unit RTL.
module ultrasonic_range_meter_unit_test;
    import urm_pkg::*;

    // Indexes past the register map; writes there must be ignored
    localparam t_reg_idx REG_SPARE6 = 3'd6;
    localparam t_reg_idx REG_SPARE7 = 3'd7;

    // Echo levels for the hand-built opening sequence, first tick leftmost
    localparam bit [0:23] OPENING_ECHO = 24'b0010_0111_0001_1000_0011_0010;

    typedef struct packed {
        bit              trig;
        bit [DIST_W-1:0] dq8;
        bit              ok;
        bit              done;
    } reading_t;

    // Mirror of the sequencer: register copies, phase state, pending readings
    class ranger_mirror;
        bit               enable;
        bit [TICK_W-1:0]  idle_ticks;
        bit [TRIG_W-1:0]  trigger_ticks;
        bit [TICK_W-1:0]  timeout_ticks;
        bit [SCALE_W-1:0] scale_q16;
        bit [MAXD_W-1:0]  max_cm;

        t_phase                phase;
        bit [COUNT_BITS-1:0]   ticks;
        bit [COUNT_BITS-1:0]   width;
        bit                    prev_echo;
        bit [DIST_W-1:0]       last_dist;
        bit                    last_ok;

        reading_t pending_readings[$];
        int errors, ticks_noted, readings_seen, stored_seen, in_range_seen;

        function new();
            enable        = 1'b0;
            idle_ticks    = 20'd500000;
            trigger_ticks = 8'd10;
            timeout_ticks = 20'd200000;
            scale_q16     = 16'd1124;
            max_cm        = 9'd100;
            phase         = PH_IDLE;
            ticks         = '0;
            width         = '0;
            prev_echo     = 1'b0;
            last_dist     = '0;
            last_ok       = 1'b0;
        endfunction

        function void write_reg(t_reg_idx idx, bit [PDATA_W-1:0] value);
            case (idx)
                REG_ENABLE:  enable        = value[0];
                REG_IDLE:    idle_ticks    = value[TICK_W-1:0];
                REG_TRIGGER: trigger_ticks = value[TRIG_W-1:0];
                REG_TIMEOUT: timeout_ticks = value[TICK_W-1:0];
                REG_SCALE:   scale_q16     = value[SCALE_W-1:0];
                REG_MAXDIST: max_cm        = value[MAXD_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [PDATA_W-1:0] reg_value(t_reg_idx idx);
            case (idx)
                REG_ENABLE:  return PDATA_W'(enable);
                REG_IDLE:    return PDATA_W'(idle_ticks);
                REG_TRIGGER: return PDATA_W'(trigger_ticks);
                REG_TIMEOUT: return PDATA_W'(timeout_ticks);
                REG_SCALE:   return PDATA_W'(scale_q16);
                REG_MAXDIST: return PDATA_W'(max_cm);
                default:     return '0;
            endcase
        endfunction

        // Counters stop at all ones
        function bit [COUNT_BITS-1:0] sat_inc(bit [COUNT_BITS-1:0] c);
            return (&c) ? c : c + 1'b1;
        endfunction

        // A zero target acts as one; a saturated counter ends the wait too
        function bit hit(bit [COUNT_BITS-1:0] c, bit [COUNT_BITS-1:0] target);
            bit [COUNT_BITS-1:0] t;
            t = (target == 0) ? COUNT_BITS'(1) : target;
            return (c >= t) || (&c);
        endfunction

        function void store_lost();
            last_dist = '0;
            last_ok   = 1'b0;
        endfunction

        // Width times Q16 scale, compared against the limit in Q16 cm
        function void store_width(bit [COUNT_BITS-1:0] w);
            bit [COUNT_BITS+SCALE_W-1:0] p;
            bit [COUNT_BITS+SCALE_W-1:0] lim;
            p   = w;
            p   = p * scale_q16;
            lim = max_cm;
            lim = lim << 16;
            if (p > lim) begin
                store_lost();
            end else begin
                last_dist = p[DIST_W+7:8];
                last_ok   = 1'b1;
            end
        endfunction

        // One accepted tick request: advance the sequencer and queue its reading
        function void note_tick(bit echo);
            reading_t r;
            r = '0;
            if (!enable) begin
                phase = PH_IDLE;
                ticks = '0;
                width = '0;
            end else begin
                case (phase)
                    PH_IDLE: begin
                        ticks = sat_inc(ticks);
                        if (hit(ticks, idle_ticks)) begin
                            phase = PH_TRIG;
                            ticks = '0;
                        end
                    end
                    PH_TRIG: begin
                        r.trig = 1'b1;
                        ticks  = sat_inc(ticks);
                        if (hit(ticks, trigger_ticks)) begin
                            phase = PH_RISE;
                            ticks = '0;
                        end
                    end
                    PH_RISE: begin
                        if (echo && !prev_echo) begin
                            phase = PH_HIGH;
                            width = COUNT_BITS'(1);
                            ticks = '0;
                        end else begin
                            ticks = sat_inc(ticks);
                            if (hit(ticks, timeout_ticks)) begin
                                store_lost();
                                r.done = 1'b1;
                                phase  = PH_IDLE;
                                ticks  = '0;
                            end
                        end
                    end
                    default: begin
                        if (!echo) begin
                            store_width(width);
                            r.done = 1'b1;
                            phase  = PH_IDLE;
                            ticks  = '0;
                        end else begin
                            width = sat_inc(width);
                            if (hit(width, timeout_ticks)) begin
                                store_lost();
                                r.done = 1'b1;
                                phase  = PH_IDLE;
                                ticks  = '0;
                            end
                        end
                    end
                endcase
            end
            prev_echo = echo;
            r.dq8 = last_dist;
            r.ok  = last_ok;
            pending_readings.push_back(r);
            ticks_noted++;
        endfunction

        // Compare one accepted reading with the oldest prediction
        function void check_reading(logic trig, logic [DIST_W-1:0] dq8, logic ok, logic done);
            reading_t e;
            if (pending_readings.size() == 0) begin
                $error("reading with no tick request pending");
                errors++;
                return;
            end
            e = pending_readings.pop_front();
            readings_seen++;
            if (e.done) stored_seen++;
            if (e.done && e.ok) in_range_seen++;
            if (trig !== e.trig) begin
                $error("trigger_level: expected %0d, got %0d", e.trig, trig);
                errors++;
            end
            if (dq8 !== e.dq8) begin
                $error("distance_q8: expected %0d, got %0d", e.dq8, dq8);
                errors++;
            end
            if (ok !== e.ok) begin
                $error("in_range: expected %0d, got %0d", e.ok, ok);
                errors++;
            end
            if (done !== e.done) begin
                $error("reading_done: expected %0d, got %0d", e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_echo_level = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_trigger_level;
    logic [DIST_W-1:0]  o_distance_q8;
    logic               o_in_range;
    logic               o_reading_done;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ranger_mirror mirror = new();

    // Random idling switches and echo shaping state
    bit in_gaps  = 1'b1;
    bit out_gaps = 1'b1;
    bit long_pulses = 1'b0;
    int rise_wait = 0;
    int high_left = 1;
    int wmax = 8;
    int settings_done = 0;

    ultrasonic_range_meter_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_trigger_level (o_trigger_level),
        .o_distance_q8   (o_distance_q8),
        .o_in_range      (o_in_range),
        .o_reading_done  (o_reading_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    // Echo level that follows a well-formed pulse for the phase the block is in,
    // with some noise mixed in
    function automatic bit next_echo();
        int te;
        bit e;
        te = (mirror.timeout_ticks == 0) ? 1 : int'(mirror.timeout_ticks);
        e = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            e = 1'($urandom_range(0, 1));
        end else begin
            case (mirror.phase)
                PH_RISE: begin
                    if (rise_wait > 0) begin
                        rise_wait--;
                    end else begin
                        e = 1'b1;
                    end
                end
                PH_HIGH: begin
                    if (high_left > 1) begin
                        high_left--;
                        e = 1'b1;
                    end
                end
                default: begin
                    // re-arm the next pulse; now and then echo is already high
                    if (long_pulses) begin
                        rise_wait = $urandom_range(0, 5);
                        high_left = $urandom_range(380, 420);
                    end else begin
                        rise_wait = $urandom_range(0, (te + 1 < 80) ? te + 1 : 80);
                        high_left = $urandom_range(1, (te + 2 < wmax) ? te + 2 : wmax);
                    end
                    e = ($urandom_range(0, 9) == 0);
                end
            endcase
        end
        return e;
    endfunction

    // Offer one tick request and wait until it is taken
    task automatic send_tick(bit echo);
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_echo_level <= echo;
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_tick(echo);
    endtask

    // Stop offering and wait for every predicted reading to arrive
    task automatic drain();
        i_in_valid <= 1'b0;
        while (mirror.pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic read_back(t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== mirror.reg_value(idx)) begin
            $error("register %0d: expected %0h, got %0h", idx, mirror.reg_value(idx), prdata);
            mirror.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, bit [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx <= REG_MAXDIST) read_back(idx);
    endtask

    // New setting for every register; junk above each field checks the masking
    task automatic randomize_config();
        bit [PDATA_W-1:0] v;
        v = ($urandom_range(0, 6) != 0);
        write_register(REG_ENABLE, v | ($urandom() << 1));
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 1;
            default: v = $urandom_range(2, 8);
        endcase
        write_register(REG_IDLE, v | ($urandom() << TICK_W));
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 1;
            2:       v = 255;
            default: v = $urandom_range(2, 5);
        endcase
        write_register(REG_TRIGGER, v | ($urandom() << TRIG_W));
        case ($urandom_range(0, 6))
            0:       v = 0;
            1:       v = 1;
            2:       v = $urandom_range(0, 20'hFFFFF);
            default: v = $urandom_range(2, 60);
        endcase
        write_register(REG_TIMEOUT, v | ($urandom() << TICK_W));
        case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = 16'hFFFF;
            default: v = $urandom_range(0, 16'hFFFF);
        endcase
        write_register(REG_SCALE, v | ($urandom() << SCALE_W));
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 400;
            2:       v = 511;
            default: v = $urandom_range(0, 60);
        endcase
        write_register(REG_MAXDIST, v | ($urandom() << MAXD_W));
        settings_done++;
    endtask

    // Reading side: check what is taken, stall in short random bursts
    initial begin : reading_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                mirror.check_reading(o_trigger_level, o_distance_q8, o_in_range, o_reading_done);
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (out_gaps && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #800000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then a few ticks with the loop halted
        for (int r = REG_ENABLE; r <= REG_MAXDIST; r++) read_back(t_reg_idx'(r));
        repeat (4) send_tick(1'($urandom_range(0, 1)));
        drain();

        // Shortest waits: clean pulse in range, echo high after trigger,
        // pulse timeout and rise timeout
        write_register(REG_IDLE, 1);
        write_register(REG_TRIGGER, 1);
        write_register(REG_TIMEOUT, 2);
        write_register(REG_SCALE, 16'hFFFF);
        write_register(REG_MAXDIST, 1);
        write_register(REG_ENABLE, 1);
        settings_done++;
        for (int i = 0; i < 24; i++) send_tick(OPENING_ECHO[i]);
        drain();

        // Random settings; the last few phases run without idling
        for (int p = 0; p < 28; p++) begin
            in_gaps     = (p < 24);
            out_gaps    = (p < 24);
            long_pulses = 1'b0;
            n = 25;
            case (p)
                3: begin
                    // longest idle wait; counting is cut short by the next setting
                    write_register(REG_IDLE, 20'hFFFFF);
                    write_register(REG_ENABLE, 1);
                    settings_done++;
                    n = 12;
                end
                5: begin
                    // long pulses near the 400 cm limit, longest timeout
                    write_register(REG_ENABLE, 1);
                    write_register(REG_IDLE, 2);
                    write_register(REG_TRIGGER, 1);
                    write_register(REG_TIMEOUT, 20'hFFFFF);
                    write_register(REG_SCALE, 16'hFFFF);
                    write_register(REG_MAXDIST, 400);
                    settings_done++;
                    long_pulses = 1'b1;
                    n = 800;
                end
                7: begin
                    write_register(REG_SPARE6, $urandom());
                    write_register(REG_SPARE7, $urandom());
                    randomize_config();
                end
                default: randomize_config();
            endcase
            wmax = 70;
            repeat (n) send_tick(next_echo());
            drain();
        end

        // Let any stray reading show up
        repeat (8) @(posedge i_clk);
        $display("Covered %0d tick requests over %0d register settings;",
                 mirror.ticks_noted, settings_done);
        $display("%0d readings checked, %0d measurements stored, %0d of them in range",
                 mirror.readings_seen, mirror.stored_seen, mirror.in_range_seen);
        if (mirror.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: ultrasonic_range_meter_unit.f
sv/urm_pkg.sv
sv/ultrasonic_range_meter_unit.sv
tb/sv/ultrasonic_range_meter_unit_test.sv
